// File: src/vic_pkg.sv
// Types, codes and helper functions of the vectored interrupt controller.
// No dependencies; every other file of the block but vic_if imports this package.
package vic_pkg;

  localparam int unsigned LineCount   = 32;
  localparam int unsigned DataBits    = 32;
  localparam int unsigned FieldAdrBits = 10;
  localparam int unsigned RegCount    = 9;
  localparam int unsigned OffsetBits  = 4;

  localparam logic [DataBits-1:0]     VecBaseMask    = 32'hFFFF_FFFC;
  localparam logic [DataBits-1:0]     VecSetupMask   = 32'hFFFF_FFFD;
  localparam logic [FieldAdrBits-1:0] RegBaseReset   = 10'h0C0;

  typedef enum logic [1:0] {
    OP_LINE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } vic_op_e;

  typedef enum logic [OffsetBits-1:0] {
    REG_STATUS     = 4'd0,
    REG_SET_STATUS = 4'd1,
    REG_ENABLE     = 4'd2,
    REG_CRITICAL   = 4'd3,
    REG_PRIORITY   = 4'd4,
    REG_TRIGGER    = 4'd5,
    REG_MASKED     = 4'd6,
    REG_VECTOR     = 4'd7,
    REG_VEC_CONFIG = 4'd8
  } vic_reg_e;

  typedef enum logic [0:0] {
    CFG_REGISTER_BASE   = 1'b0,
    CFG_VECTORS_ENABLED = 1'b1
  } vic_cfg_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [4:0]              line_number;
    logic                    line_level;
    logic [FieldAdrBits-1:0] register_address;
    logic [DataBits-1:0]     write_data;
  } vic_item_t;

  typedef struct packed {
    logic [DataBits-1:0] read_data;
    logic                interrupt_out;
    logic                critical_out;
  } vic_result_t;

  typedef struct packed {
    logic [FieldAdrBits-1:0] register_base;
    logic                    vectors_enabled;
  } vic_cfg_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [4:0] vic_lowest_set(input logic [LineCount-1:0] bits);
    logic [4:0] idx;
    idx = '0;
    for (int i = LineCount - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [LineCount-1:0] vic_reverse(input logic [LineCount-1:0] bits);
    logic [LineCount-1:0] rev;
    for (int i = 0; i < LineCount; i++) begin
      rev[i] = bits[LineCount-1-i];
    end
    return rev;
  endfunction

endpackage

// File: src/vic_if.sv
// Handshake channels of the vectored interrupt controller: item, result
// and configuration write. No dependencies; the field widths are written as literals.
interface vic_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [4:0]  line_number;
  logic        line_level;
  logic [9:0]  register_address;
  logic [31:0] write_data;

  modport source (output valid, operation, line_number, line_level, register_address,
                  write_data, input ready);
  modport sink (input valid, operation, line_number, line_level, register_address,
                write_data, output ready);
endinterface

interface vic_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        interrupt_out;
  logic        critical_out;

  modport source (output valid, read_data, interrupt_out, critical_out, input ready);
  modport sink (input valid, read_data, interrupt_out, critical_out, output ready);
endinterface

interface vic_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/vic_regs.sv
// Device registers of the controller: line latching, bus decode, register
// reads and writes, and the critical vector. Depends on vic_pkg.
module vic_regs #(
  parameter int unsigned BUS_ADDRESS_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vic_pkg::vic_cfg_t   cfg_i,
  input  logic                fire_i,
  input  vic_pkg::vic_item_t  item_i,
  output vic_pkg::vic_result_t result_o
);
  import vic_pkg::*;

  // Addresses wider than the bus field cannot differ above it.
  localparam int unsigned CmpBits =
      (BUS_ADDRESS_BITS < FieldAdrBits) ? BUS_ADDRESS_BITS : FieldAdrBits;

  logic [DataBits-1:0] status_q, status_d;
  logic [DataBits-1:0] enable_q, enable_d;
  logic [DataBits-1:0] crit_sel_q, crit_sel_d;
  logic [DataBits-1:0] priority_q, priority_d;
  logic [DataBits-1:0] edge_mode_q, edge_mode_d;
  logic [DataBits-1:0] active_q, active_d;
  logic [DataBits-1:0] vec_setup_q, vec_setup_d;
  logic [DataBits-1:0] vec_value_q, vec_value_d;

  logic [CmpBits-1:0]    adr;
  logic [CmpBits-1:0]    base;
  logic [CmpBits-1:0]    offset_full;
  logic                  hit;
  logic [OffsetBits-1:0] offset;
  logic [DataBits-1:0]   line_mask;
  logic                  is_edge;
  logic                  update_vec;
  logic [DataBits-1:0]   crit_pending;
  logic [4:0]            crit_pos;
  logic [DataBits-1:0]   read_data;

  assign adr         = item_i.register_address[CmpBits-1:0];
  assign base        = cfg_i.register_base[CmpBits-1:0];
  assign offset_full = adr - base;
  assign hit         = (adr >= base) && (offset_full < CmpBits'(RegCount));
  assign offset      = offset_full[OffsetBits-1:0];
  assign line_mask   = 32'h8000_0000 >> item_i.line_number;
  assign is_edge     = |(edge_mode_q & line_mask);

  always_comb begin
    status_d    = status_q;
    enable_d    = enable_q;
    crit_sel_d  = crit_sel_q;
    priority_d  = priority_q;
    edge_mode_d = edge_mode_q;
    active_d    = active_q;
    vec_setup_d = vec_setup_q;
    update_vec  = 1'b0;
    read_data   = '0;
    case (item_i.operation)
      OP_LINE: begin
        if (is_edge) begin
          if (item_i.line_level) begin
            status_d = status_q | line_mask;
          end
        end else if (item_i.line_level) begin
          status_d = status_q | line_mask;
          active_d = active_q | line_mask;
        end else begin
          status_d = status_q & ~line_mask;
          active_d = active_q & ~line_mask;
        end
        update_vec = (status_d != status_q);
      end
      OP_READ: begin
        if (hit) begin
          case (offset)
            REG_STATUS, REG_SET_STATUS: read_data = status_q;
            REG_ENABLE:     read_data = enable_q;
            REG_CRITICAL:   read_data = crit_sel_q;
            REG_PRIORITY:   read_data = priority_q;
            REG_TRIGGER:    read_data = edge_mode_q;
            REG_MASKED:     read_data = status_q & enable_q;
            REG_VECTOR:     read_data = cfg_i.vectors_enabled ? vec_value_q : '0;
            REG_VEC_CONFIG: read_data = cfg_i.vectors_enabled ? vec_setup_q : '0;
            default:        read_data = '0;
          endcase
        end
      end
      OP_WRITE: begin
        if (hit) begin
          case (offset)
            REG_STATUS: begin
              // Clearing a bit of a line still held high leaves it set.
              status_d   = (status_q & ~item_i.write_data) | active_q;
              update_vec = 1'b1;
            end
            REG_SET_STATUS: begin
              status_d   = status_q | item_i.write_data;
              update_vec = 1'b1;
            end
            REG_ENABLE: begin
              enable_d   = item_i.write_data;
              update_vec = 1'b1;
            end
            REG_CRITICAL: begin
              crit_sel_d = item_i.write_data;
              update_vec = 1'b1;
            end
            REG_PRIORITY: priority_d = item_i.write_data;
            REG_TRIGGER: begin
              edge_mode_d = item_i.write_data;
              update_vec  = 1'b1;
            end
            REG_VEC_CONFIG: begin
              vec_setup_d = item_i.write_data & VecSetupMask;
              update_vec  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Bit 0 of the vector setup turns the scan round: the position then
  // counts down from bit 31, which is the lowest set bit of the reversed word.
  assign crit_pending = status_d & enable_d & crit_sel_d;
  assign crit_pos     = vic_lowest_set(vec_setup_d[0] ? vic_reverse(crit_pending)
                                                      : crit_pending);

  always_comb begin
    vec_value_d = vec_value_q;
    if (update_vec) begin
      if (crit_pending == '0) begin
        vec_value_d = '0;
      end else if (cfg_i.vectors_enabled) begin
        vec_value_d = (vec_setup_d & VecBaseMask) + {18'd0, crit_pos, 9'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= '0;
      enable_q    <= '0;
      crit_sel_q  <= '0;
      priority_q  <= '0;
      edge_mode_q <= '0;
      active_q    <= '0;
      vec_setup_q <= '0;
      vec_value_q <= '0;
    end else if (fire_i) begin
      status_q    <= status_d;
      enable_q    <= enable_d;
      crit_sel_q  <= crit_sel_d;
      priority_q  <= priority_d;
      edge_mode_q <= edge_mode_d;
      active_q    <= active_d;
      vec_setup_q <= vec_setup_d;
      vec_value_q <= vec_value_d;
    end
  end

  assign result_o.read_data     = read_data;
  assign result_o.interrupt_out = |(status_d & enable_d & ~crit_sel_d);
  assign result_o.critical_out  = |crit_pending;

endmodule

// File: src/vectored_interrupt_controller.sv
// Vectored interrupt controller, 32 lines, nine bus registers.
// Each item is held in the input register and then in the result register,
// which offers its result beat; a stall on the result side holds both.
// Throughput: one item per cycle while the result side takes its beats;
// both registers also move while the result register is empty.
// Reset clears all device registers to zero, sets the register base to 0xC0
// and enables vectors; no clearing pass, items are taken at once.
module vectored_interrupt_controller #(
  parameter int unsigned BUS_ADDRESS_BITS = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vic_item_if.sink     item_i,
  vic_result_if.source result_o,
  vic_cfg_if.sink      cfg_i
);
  import vic_pkg::*;

  logic        in_valid_q, in_valid_d;
  vic_item_t   in_item_q;
  logic        res_valid_q, res_valid_d;
  vic_result_t res_q;
  vic_result_t res_d;
  vic_cfg_t    cfg_q;
  logic        advance;
  logic        fire;
  logic        item_beat;

  assign advance   = !res_valid_q || result_o.ready;
  assign fire      = in_valid_q && advance;
  assign item_i.ready = !in_valid_q || advance;
  assign item_beat = item_i.valid && item_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (item_beat) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    res_valid_d = advance ? in_valid_q : res_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_beat) begin
      in_item_q.operation        <= item_i.operation;
      in_item_q.line_number      <= item_i.line_number;
      in_item_q.line_level       <= item_i.line_level;
      in_item_q.register_address <= item_i.register_address;
      in_item_q.write_data       <= item_i.write_data;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Configuration is to be written by the user only while the block is idle; the block does not enforce this.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.register_base   <= RegBaseReset;
      cfg_q.vectors_enabled <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_REGISTER_BASE:   cfg_q.register_base   <= cfg_i.data[FieldAdrBits-1:0];
        CFG_VECTORS_ENABLED: cfg_q.vectors_enabled <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  vic_regs #(
    .BUS_ADDRESS_BITS(BUS_ADDRESS_BITS)
  ) u_vic_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .fire_i  (fire),
    .item_i  (in_item_q),
    .result_o(res_d)
  );

  assign result_o.valid         = res_valid_q;
  assign result_o.read_data     = res_q.read_data;
  assign result_o.interrupt_out = res_q.interrupt_out;
  assign result_o.critical_out  = res_q.critical_out;

endmodule

// File: tb/vic_tb_pkg.sv
// Scoreboard of the vectored interrupt controller testbench: it predicts the
// result of every item beat from its own copy of the device state and checks
// the result beats in order. Depends on vic_pkg for types and codes.
package vic_tb_pkg;
  import vic_pkg::*;

  localparam logic [DataBits-1:0] VectorStride = 32'd512;
  localparam int unsigned PrintCap = 40;

  class vic_scoreboard;
    logic [DataBits-1:0]     status_bits;
    logic [DataBits-1:0]     enable_bits;
    logic [DataBits-1:0]     critical_bits;
    logic [DataBits-1:0]     priority_bits;
    logic [DataBits-1:0]     edge_bits;
    logic [DataBits-1:0]     level_bits;
    logic [DataBits-1:0]     vec_setup;
    logic [DataBits-1:0]     vec_value;
    logic [FieldAdrBits-1:0] reg_base;
    logic                    vec_on;
    vic_result_t             awaited_q[$];
    int unsigned             mismatches;
    int unsigned             beats_checked;
    int unsigned             vectors_read;

    function new();
      status_bits   = '0;
      enable_bits   = '0;
      critical_bits = '0;
      priority_bits = '0;
      edge_bits     = '0;
      level_bits    = '0;
      vec_setup     = '0;
      vec_value     = '0;
      reg_base      = RegBaseReset;
      vec_on        = 1'b1;
      mismatches    = 0;
      beats_checked = 0;
      vectors_read  = 0;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    function void write_config(vic_cfg_e idx, logic [DataBits-1:0] data);
      if (idx == CFG_REGISTER_BASE) begin
        reg_base = data[FieldAdrBits-1:0];
      end else begin
        vec_on = data[0];
      end
    endfunction

    // With no critical source pending the vector is cleared; with vectors
    // switched off a pending source leaves the last value standing.
    function void recompute_vector();
      logic [DataBits-1:0] crit;
      int unsigned pos;
      crit = status_bits & enable_bits & critical_bits;
      pos = 0;
      if (crit == '0) begin
        vec_value = '0;
        return;
      end
      if (!vec_on) begin
        return;
      end
      if (vec_setup[0]) begin
        // Downward scan: the highest set bit wins, counted from bit 31.
        for (int i = 0; i < LineCount; i++) begin
          if (crit[i]) begin
            pos = 31 - i;
          end
        end
      end else begin
        for (int i = LineCount - 1; i >= 0; i--) begin
          if (crit[i]) begin
            pos = i;
          end
        end
      end
      vec_value = (vec_setup & VecBaseMask) + 32'(pos) * VectorStride;
    endfunction

    function void note_item(vic_item_t it);
      logic [DataBits-1:0]     line_mask;
      logic [DataBits-1:0]     old_status;
      logic [DataBits-1:0]     data;
      logic [FieldAdrBits-1:0] offset;
      logic                    hit;
      vic_result_t             want;
      want.read_data = '0;
      data = it.write_data;
      offset = it.register_address - reg_base;
      hit = (it.register_address >= reg_base) && (offset < RegCount);
      case (it.operation)
        OP_LINE: begin
          line_mask = 32'h1 << (31 - it.line_number);
          old_status = status_bits;
          if (edge_bits & line_mask) begin
            if (it.line_level) begin
              status_bits |= line_mask;
            end
          end else if (it.line_level) begin
            status_bits |= line_mask;
            level_bits |= line_mask;
          end else begin
            status_bits &= ~line_mask;
            level_bits &= ~line_mask;
          end
          if (status_bits != old_status) begin
            recompute_vector();
          end
        end
        OP_READ: begin
          if (hit) begin
            case (vic_reg_e'(offset[OffsetBits-1:0]))
              REG_STATUS, REG_SET_STATUS: want.read_data = status_bits;
              REG_ENABLE:     want.read_data = enable_bits;
              REG_CRITICAL:   want.read_data = critical_bits;
              REG_PRIORITY:   want.read_data = priority_bits;
              REG_TRIGGER:    want.read_data = edge_bits;
              REG_MASKED:     want.read_data = status_bits & enable_bits;
              REG_VECTOR:     want.read_data = vec_on ? vec_value : '0;
              REG_VEC_CONFIG: want.read_data = vec_on ? vec_setup : '0;
              default:        want.read_data = '0;
            endcase
            if (vic_reg_e'(offset[OffsetBits-1:0]) == REG_VECTOR && want.read_data != '0) begin
              vectors_read++;
            end
          end
        end
        OP_WRITE: begin
          if (hit) begin
            case (vic_reg_e'(offset[OffsetBits-1:0]))
              REG_STATUS: begin
                // Level lines that are still asserted survive the clear.
                status_bits = (status_bits & ~data) | level_bits;
                recompute_vector();
              end
              REG_SET_STATUS: begin
                status_bits |= data;
                recompute_vector();
              end
              REG_ENABLE: begin
                enable_bits = data;
                recompute_vector();
              end
              REG_CRITICAL: begin
                critical_bits = data;
                recompute_vector();
              end
              REG_PRIORITY: priority_bits = data;
              REG_TRIGGER: begin
                edge_bits = data;
                recompute_vector();
              end
              REG_VEC_CONFIG: begin
                vec_setup = data & VecSetupMask;
                recompute_vector();
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      want.interrupt_out = |(status_bits & enable_bits & ~critical_bits);
      want.critical_out  = |(status_bits & enable_bits & critical_bits);
      awaited_q.push_back(want);
    endfunction

    task report_mismatch(string what, logic [DataBits-1:0] got, logic [DataBits-1:0] want);
      mismatches++;
      if (mismatches <= PrintCap) begin
        $display("[%0t] result %0d: %s is %h, predicted %h", $time, beats_checked, what, got,
                 want);
      end
    endtask

    task check_result(vic_result_t got);
      vic_result_t want;
      if (awaited_q.size() == 0) begin
        report_mismatch("unexpected result beat, read_data", got.read_data, '0);
        return;
      end
      want = awaited_q.pop_front();
      beats_checked++;
      if (got.read_data !== want.read_data) begin
        report_mismatch("read_data", got.read_data, want.read_data);
      end
      if (got.interrupt_out !== want.interrupt_out) begin
        report_mismatch("interrupt_out", 32'(got.interrupt_out), 32'(want.interrupt_out));
      end
      if (got.critical_out !== want.critical_out) begin
        report_mismatch("critical_out", 32'(got.critical_out), 32'(want.critical_out));
      end
    endtask
  endclass

endpackage

// File: tb/tb_vectored_interrupt_controller.sv
// Top level of the vectored interrupt controller testbench: clock, reset,
// item and configuration drivers, result sink and watchdog.
// Depends on vic_pkg, the channel interfaces and vic_tb_pkg.
module tb_vectored_interrupt_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import vic_pkg::*;
  import vic_tb_pkg::*;

  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned AddrTop     = (1 << FieldAdrBits) - 1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vic_item_if   item_bus ();
  vic_result_if result_bus ();
  vic_cfg_if    cfg_bus ();

  vectored_interrupt_controller dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  vic_scoreboard sb = new();
  int unsigned burst_left   = 0;
  int unsigned items_sent   = 0;
  int unsigned useful_total = 0;
  int unsigned cfg_writes   = 0;
  int unsigned settings_run = 1;
  int unsigned idle_cycles  = 0;

  always #5ns clk_i = ~clk_i;

  function automatic vic_item_t make_item(logic [1:0] op, logic [4:0] line, logic lvl,
                                          logic [FieldAdrBits-1:0] addr,
                                          logic [DataBits-1:0] data);
    vic_item_t it;
    it.operation        = op;
    it.line_number      = line;
    it.line_level       = lvl;
    it.register_address = addr;
    it.write_data       = data;
    return it;
  endfunction

  function automatic logic [FieldAdrBits-1:0] reg_addr(vic_reg_e r);
    return sb.reg_base + FieldAdrBits'(r);
  endfunction

  // Write data biased towards sparse and extreme masks so that single
  // critical sources and their vectors turn up often.
  function automatic logic [DataBits-1:0] random_data();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      4:       return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic vic_item_t random_item(output bit useful);
    vic_item_t   it;
    int unsigned pick;
    int unsigned target;
    it = make_item(OP_LINE, 5'($urandom), 1'($urandom), FieldAdrBits'($urandom), $urandom);
    pick = $urandom_range(0, 99);
    target = sb.reg_base + $urandom_range(0, RegCount - 1);
    if (target > AddrTop) begin
      target = sb.reg_base;
    end
    useful = 1'b1;
    if (pick >= 40 && pick < 92) begin
      it.operation = (pick < 65) ? OP_READ : OP_WRITE;
      it.register_address = FieldAdrBits'(target);
      it.write_data = random_data();
    end else if (pick >= 92 && pick < 97) begin
      // Noise: an access anywhere on the bus, usually off the device.
      it.operation = pick[0] ? OP_READ : OP_WRITE;
      useful = 1'b0;
    end else if (pick >= 97) begin
      it.operation = OpUnused;
      useful = 1'b0;
    end
    return it;
  endfunction

  task automatic send_item(input vic_item_t it);
    item_bus.valid            <= 1'b1;
    item_bus.operation        <= it.operation;
    item_bus.line_number      <= it.line_number;
    item_bus.line_level       <= it.line_level;
    item_bus.register_address <= it.register_address;
    item_bus.write_data       <= it.write_data;
    do begin
      @(posedge clk_i);
    end while (!item_bus.ready);
    sb.note_item(it);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 12);
    end
  endtask

  // Stops offering items until every predicted result beat has been taken.
  task automatic drain();
    item_bus.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Both registers are written back to back with valid held high; the upper
  // data bits are random since only the low bits are stored.
  task automatic apply_setting(input logic [FieldAdrBits-1:0] base, input logic ven);
    logic [DataBits-1:0] base_word;
    logic [DataBits-1:0] ven_word;
    base_word = $urandom;
    base_word[FieldAdrBits-1:0] = base;
    ven_word = $urandom;
    ven_word[0] = ven;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_REGISTER_BASE;
    cfg_bus.data  <= base_word;
    do begin
      @(posedge clk_i);
    end while (!cfg_bus.ready);
    sb.write_config(CFG_REGISTER_BASE, base_word);
    cfg_bus.index <= CFG_VECTORS_ENABLED;
    cfg_bus.data  <= ven_word;
    do begin
      @(posedge clk_i);
    end while (!cfg_bus.ready);
    sb.write_config(CFG_VECTORS_ENABLED, ven_word);
    cfg_bus.valid <= 1'b0;
    cfg_writes += 2;
    settings_run++;
  endtask

  task automatic run_directed();
    send_item(make_item(OP_READ, 5'd0, 1'b0, reg_addr(REG_STATUS), '0));
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_ENABLE), '1));
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_CRITICAL), 32'h0000_FFFF));
    // Lowest and highest line numbers, level mode, one critical and one not.
    send_item(make_item(OP_LINE, 5'd31, 1'b1, '1, '1));
    send_item(make_item(OP_LINE, 5'd0, 1'b1, '0, '0));
    send_item(make_item(OP_READ, 5'd0, 1'b0, reg_addr(REG_VECTOR), '0));
    // Downward scan selected, with the low bits of the base dropped.
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_VEC_CONFIG), '1));
    send_item(make_item(OP_READ, 5'd0, 1'b0, reg_addr(REG_VEC_CONFIG), '0));
    send_item(make_item(OP_READ, 5'd0, 1'b0, reg_addr(REG_VECTOR), '0));
    // Status clear must keep the two lines that are still asserted.
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_STATUS), '1));
    send_item(make_item(OP_LINE, 5'd0, 1'b0, '0, '0));
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_TRIGGER), '1));
    send_item(make_item(OP_LINE, 5'd5, 1'b1, '0, '0));
    send_item(make_item(OP_LINE, 5'd5, 1'b0, '0, '0));
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_STATUS), 32'h0400_0000));
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_SET_STATUS), 32'h8000_0001));
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_PRIORITY), 32'hA5A5_A5A5));
    send_item(make_item(OP_READ, 5'd0, 1'b0, reg_addr(REG_PRIORITY), '0));
    send_item(make_item(OP_READ, 5'd0, 1'b0, reg_addr(REG_MASKED), '0));
    send_item(make_item(OP_READ, 5'd0, 1'b0, reg_addr(REG_TRIGGER), '0));
    // Read-only registers ignore writes.
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_MASKED), '1));
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, reg_addr(REG_VECTOR), '1));
    send_item(make_item(OpUnused, 5'd31, 1'b1, reg_addr(REG_STATUS), '1));
    // Addresses below the base and past the last register.
    send_item(make_item(OP_READ, 5'd0, 1'b0, '0, '0));
    send_item(make_item(OP_WRITE, 5'd0, 1'b0, '1, '1));
  endtask

  // Result side: stretches of steady, random and periodic readiness, plus
  // one long hold-off so that the block fills up and stalls its input.
  initial begin : result_side
    int unsigned stretch;
    int unsigned mode;
    int unsigned tick;
    bit          held;
    stretch = 0;
    mode = 0;
    tick = 0;
    held = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && sb.beats_checked >= 400) begin
        held = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      if (stretch == 0) begin
        mode = $urandom_range(0, 2);
        stretch = $urandom_range(5, 60);
      end
      stretch--;
      tick++;
      case (mode)
        0:       result_bus.ready <= 1'b1;
        1:       result_bus.ready <= ($urandom_range(0, 99) < 60);
        default: result_bus.ready <= (tick % 3 != 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      sb.check_result(vic_result_t'{result_bus.read_data, result_bus.interrupt_out,
                                    result_bus.critical_out});
    end
  end

  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("[%0t] no beat for %0d cycles, %0d results outstanding", $time, StallLimit,
               sb.pending());
      $display("tb_vectored_interrupt_controller NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [FieldAdrBits-1:0] phase_base [6];
    logic                    phase_ven [6];
    int unsigned             phase_quota [6];
    vic_item_t               it;
    bit                      useful;
    int unsigned             done;
    item_bus.valid            <= 1'b0;
    item_bus.operation        <= OP_LINE;
    item_bus.line_number      <= '0;
    item_bus.line_level       <= 1'b0;
    item_bus.register_address <= '0;
    item_bus.write_data       <= '0;
    cfg_bus.valid             <= 1'b0;
    cfg_bus.index             <= CFG_REGISTER_BASE;
    cfg_bus.data              <= '0;
    phase_base  = '{10'd0, 10'h3FF, 10'd1015, FieldAdrBits'($urandom), FieldAdrBits'($urandom),
                    RegBaseReset};
    phase_ven   = '{1'b1, 1'b0, 1'b0, 1'b1, 1'($urandom), 1'b1};
    phase_quota = '{200, 100, 200, 250, 250, 200};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int p = 0; p < 6; p++) begin
      drain();
      apply_setting(phase_base[p], phase_ven[p]);
      done = 0;
      while (done < phase_quota[p]) begin
        it = random_item(useful);
        send_item(it);
        if (useful) begin
          done++;
          useful_total++;
          if (p == 2 && done == 100) begin
            drain();
          end
        end
      end
    end
    drain();

    $display("Covered %0d item beats (%0d aimed at live registers or lines), %0d results checked.",
             items_sent, useful_total, sb.beats_checked);
    $display("%0d configuration writes over %0d settings; %0d non-zero critical vectors read.",
             cfg_writes, settings_run, sb.vectors_read);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_vectored_interrupt_controller OK");
    end else begin
      $display("tb_vectored_interrupt_controller NOT OK");
    end
    $finish;
  end

endmodule
